@@ hw/rtl/adce_pkg.sv @@
// ----------------------------------------------------------------------------
// adce_pkg
// Types and constants shared by the distinct count estimator: request and
// result payloads, command codes, level limits and the sampling test.
// ----------------------------------------------------------------------------
package adce_pkg;

    localparam logic       CMD_OFFER   = 1'b0;
    localparam logic       CMD_CLEAR   = 1'b1;
    localparam logic [9:0] LIMIT_RESET = 10'd1000;
    localparam logic [5:0] LEVEL_MAX   = 6'd48;

    typedef struct packed {
        logic        command;
        logic [63:0] hash_value;
    } t_req;

    typedef struct packed {
        logic [58:0] estimate;
        logic [10:0] stored_count;
        logic [5:0]  sample_level;
        logic [31:0] records_seen;
    } t_rsp;

    // True when the low lv bits of h are all zero
    function automatic logic passes(input logic [63:0] h, input logic [5:0] lv);
        logic [63:0] mask;
        mask = (64'd1 << lv) - 64'd1;
        return (h & mask) == 64'd0;
    endfunction

endpackage

@@ hw/rtl/adaptive_distinct_count_estimator.sv @@
// ----------------------------------------------------------------------------
// adaptive_distinct_count_estimator
// Adaptive sampling distinct count estimator over 64-bit hashes. Sampled
// hashes live in one synchronous memory; duplicate search and compaction
// sweep it one entry per cycle.
// ----------------------------------------------------------------------------
//  channel   | signals                          | direction
//  ----------+----------------------------------+----------
//  request   | i_req_valid, o_req_ready, i_req  | in
//  result    | o_rsp_valid, i_rsp_ready, o_rsp  | out
//  config    | i_cfg_wr_en, i_cfg_wr_data       | in
//
//  A clear, or a hash failing the sampling test, goes straight to the result.
//  A sampled hash is first checked in a duplicate sweep over up to N entries held,
//  and when the level rises the store is compacted in a second sweep; both
//  sweeps run through the single memory read port.
//  Reset is synchronous; the store needs no clearing pass.
//  One request is in work at a time; a finished result waits in the output
//  register and holds the block only if it has not yet been taken.
// ----------------------------------------------------------------------------
module adaptive_distinct_count_estimator #(
    parameter int STORE_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  adce_pkg::t_req       i_req,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    output adce_pkg::t_rsp       o_rsp,
    input  logic                 i_cfg_wr_en,
    input  logic [9:0]           i_cfg_wr_data
);
    import adce_pkg::*;

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int CNT_W = AW + 1;
    localparam int CMP_W = (CNT_W > 10) ? CNT_W : 10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DUP,
        S_CHECK,
        S_COMPACT,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [63:0]        r_hash;
    logic [CNT_W-1:0]   r_cnt;
    logic [5:0]         r_level;
    logic [31:0]        r_total;
    logic [9:0]         r_limit;
    logic [CNT_W-1:0]   r_rd_idx;
    logic [CNT_W-1:0]   r_wr_idx;
    logic               r_rd_pend;
    logic               r_dup;
    logic               r_out_valid;
    t_rsp               r_out;
    logic [63:0]        r_rd_data;

    logic [63:0]        mem [STORE_DEPTH];

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [63:0]        mem_wdata;
    logic [CMP_W-1:0]   lim;
    logic               ins;
    logic [CNT_W-1:0]   cnt_new;
    logic               raise;
    logic               keep;
    logic               accept;

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    always_comb begin
        lim = (CMP_W'(r_limit) > CMP_W'(STORE_DEPTH - 1)) ? CMP_W'(STORE_DEPTH - 1)
                                                         : CMP_W'(r_limit);
        ins = !r_dup && (r_cnt < CNT_W'(STORE_DEPTH)) &&
              ((r_level < LEVEL_MAX) || (CMP_W'(r_cnt) <= lim));
        cnt_new = r_cnt + CNT_W'(ins);
        raise   = (CMP_W'(cnt_new) > lim) && (r_level < LEVEL_MAX);
        keep    = r_rd_pend && passes(r_rd_data, r_level);
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wr_idx[AW-1:0];
        mem_wdata = r_rd_data;
        unique case (r_state)
            S_CHECK: begin
                mem_we    = ins;
                mem_waddr = r_cnt[AW-1:0];
                mem_wdata = r_hash;
            end
            S_COMPACT: begin
                mem_we = keep;
            end
            S_IDLE, S_DUP, S_DONE: begin
                mem_we = 1'b0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[r_rd_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_level     <= '0;
            r_total     <= '0;
            r_limit     <= LIMIT_RESET;
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_rd_pend   <= 1'b0;
            r_dup       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (r_out_valid && i_rsp_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_hash    <= i_req.hash_value;
                        r_rd_idx  <= '0;
                        r_rd_pend <= 1'b0;
                        if (i_req.command == CMD_CLEAR) begin
                            r_cnt   <= '0;
                            r_level <= '0;
                            r_total <= '0;
                            r_state <= S_DONE;
                        end else begin
                            if (r_total != 32'hFFFF_FFFF) begin
                                r_total <= r_total + 32'd1;
                            end
                            r_state <= passes(i_req.hash_value, r_level) ? S_DUP : S_DONE;
                        end
                    end
                end
                S_DUP: begin
                    if (r_rd_pend && (r_rd_data == r_hash)) begin
                        r_dup   <= 1'b1;
                        r_state <= S_CHECK;
                    end else if (r_rd_idx < r_cnt) begin
                        r_rd_idx  <= r_rd_idx + CNT_W'(1);
                        r_rd_pend <= 1'b1;
                    end else begin
                        r_dup   <= 1'b0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_cnt     <= cnt_new;
                    r_rd_idx  <= '0;
                    r_wr_idx  <= '0;
                    r_rd_pend <= 1'b0;
                    if (raise) begin
                        r_level <= r_level + 6'd1;
                        r_state <= S_COMPACT;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_COMPACT: begin
                    if (keep) begin
                        r_wr_idx <= r_wr_idx + CNT_W'(1);
                    end
                    if (r_rd_idx < r_cnt) begin
                        r_rd_idx  <= r_rd_idx + CNT_W'(1);
                        r_rd_pend <= 1'b1;
                    end else if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                    end else begin
                        r_cnt   <= r_wr_idx;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_rsp_ready) begin
                        r_out.estimate     <= 59'(r_cnt) << r_level;
                        r_out.stored_count <= 11'(r_cnt);
                        r_out.sample_level <= r_level;
                        r_out.records_seen <= r_total;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ bench/tb_adaptive_distinct_count_estimator.sv @@
// ----------------------------------------------------------------------------
// tb_adaptive_distinct_count_estimator
// Self-checking bench for the distinct count estimator. Requests go in over a
// valid/ready channel with random gaps, results are taken with random stalls.
// A behavioural copy of the sampled set tracks level, count and record total
// and predicts every result, which is compared field by field. Tests cover
// the reset state, clears, a zero limit driving the level to its ceiling, a
// large set held at the level ceiling, a limit lowered under a held set, and
// long random streams across many limits.
// ----------------------------------------------------------------------------
module tb_adaptive_distinct_count_estimator;
    import adce_pkg::*;

    localparam int STORE_DEPTH    = 1024;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 180;
    localparam int HISTORY_DEPTH  = 64;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        req_valid   = 1'b0;
    t_req        req_data    = '0;
    logic        rsp_ready   = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [9:0]  cfg_wr_data = '0;
    logic        req_ready;
    logic        rsp_valid;
    t_rsp        rsp_data;

    logic [63:0] sample_store [0:STORE_DEPTH-1];
    logic [10:0] held_count   = '0;
    logic [5:0]  sample_lvl   = '0;
    logic [31:0] record_count = '0;
    logic [9:0]  limit_reg    = LIMIT_RESET;

    t_rsp        pending_estimates [$];
    logic [63:0] recent_hashes [$];
    int          errors       = 0;
    int          quiet_cycles = 0;
    int          stall_left   = 0;
    bit          idle_enabled = 1'b1;

    adaptive_distinct_count_estimator #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_valid),
        .o_req_ready   (req_ready),
        .i_req         (req_data),
        .o_rsp_valid   (rsp_valid),
        .i_rsp_ready   (rsp_ready),
        .o_rsp         (rsp_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic kept_at_level(input logic [63:0] h, input logic [5:0] lv);
        return (h << (7'd64 - {1'b0, lv})) == 64'd0;
    endfunction

    function automatic t_rsp estimate_next(input t_req r);
        logic [10:0] lim;
        logic [10:0] w;
        logic [63:0] scaled;
        bit          dup;
        t_rsp        e;
        if (r.command == CMD_CLEAR) begin
            held_count   = '0;
            sample_lvl   = '0;
            record_count = '0;
        end else begin
            if (record_count != 32'hFFFF_FFFF) record_count++;
            if (kept_at_level(r.hash_value, sample_lvl)) begin
                lim = {1'b0, limit_reg};
                if (lim > STORE_DEPTH - 1) lim = 11'(STORE_DEPTH - 1);
                dup = 1'b0;
                for (int i = 0; i < held_count; i++)
                    if (sample_store[i] == r.hash_value) dup = 1'b1;
                if (!dup && held_count < STORE_DEPTH &&
                    (sample_lvl < LEVEL_MAX || held_count <= lim)) begin
                    sample_store[held_count[9:0]] = r.hash_value;
                    held_count++;
                end
                if (held_count > lim && sample_lvl < LEVEL_MAX) begin
                    sample_lvl++;
                    w = '0;
                    for (int i = 0; i < held_count; i++) begin
                        if (kept_at_level(sample_store[i], sample_lvl)) begin
                            sample_store[w[9:0]] = sample_store[i];
                            w++;
                        end
                    end
                    held_count = w;
                end
            end
        end
        scaled         = {53'd0, held_count} << sample_lvl;
        e.estimate     = scaled[58:0];
        e.stored_count = held_count;
        e.sample_level = sample_lvl;
        e.records_seen = record_count;
        return e;
    endfunction

    function automatic logic [63:0] shaped_hash();
        int          pick;
        int          z;
        logic [63:0] h;
        pick = $urandom_range(99);
        h    = {$urandom, $urandom};
        if (pick < 45) begin
            z = sample_lvl + $urandom_range(0, 2);
            if (z > 63) z = 63;
            h = (h >> z) << z;
        end else if (pick < 70 && recent_hashes.size() != 0) begin
            h = recent_hashes[$urandom_range(recent_hashes.size() - 1)];
        end else if (pick < 76) begin
            case ($urandom_range(3))
                0: h = 64'd0;
                1: h = '1;
                2: h = 64'h8000_0000_0000_0000;
                default: h = 64'h7FFF_FFFF_FFFF_FFFF;
            endcase
        end
        recent_hashes.insert(recent_hashes.size(), h);
        if (recent_hashes.size() > HISTORY_DEPTH) void'(recent_hashes.pop_front());
        return h;
    endfunction

    task automatic send_request(input logic cmd, input logic [63:0] h);
        int   gap;
        bit   taken;
        t_req r;
        r.command    = cmd;
        r.hash_value = h;
        gap = idle_enabled ? pick_gap() : 0;
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do begin
            @(negedge clk);
            taken = req_ready;
            @(posedge clk);
        end while (!taken);
        pending_estimates.insert(pending_estimates.size(), estimate_next(r));
    endtask

    task automatic offer(input logic [63:0] h);
        send_request(CMD_OFFER, h);
    endtask

    task automatic clear_state();
        send_request(CMD_CLEAR, {$urandom, $urandom});
    endtask

    task automatic write_limit(input logic [9:0] v);
        req_valid <= 1'b0;
        while (pending_estimates.size() != 0) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        limit_reg = v;
    endtask

    task automatic test_reset_and_basics();
        offer(64'd0);
        offer('1);
        offer(64'h8000_0000_0000_0000);
        offer(64'd0);
        offer(64'h5555_5555_5555_5555);
        send_request(CMD_CLEAR, '1);
        offer('1);
        offer(64'hAAAA_AAAA_AAAA_AAAA);
        send_request(CMD_CLEAR, 64'd0);
    endtask

    task automatic test_zero_limit_to_ceiling();
        logic [63:0] h;
        int          z;
        clear_state();
        write_limit(10'd0);
        while (sample_lvl < LEVEL_MAX) begin
            z = sample_lvl + $urandom_range(0, 1);
            h = {$urandom, $urandom};
            offer((h >> z) << z);
        end
        offer({16'h1234, 48'd0});
        offer({16'hFEDC, 48'd0});
        offer(64'd0);
        offer('1);
        offer(64'h0001_0000_0000_0001);
    endtask

    task automatic test_ceiling_fill();
        logic [15:0] key;
        key = 16'($urandom_range(16'hFFFF));
        write_limit(10'd1023);
        idle_enabled = 1'b0;
        for (int i = 0; i < 260; i++) begin
            offer({16'(i) ^ key, 48'd0});
            if (i % 64 == 63) offer({16'(i / 2) ^ key, 48'd0});
        end
        idle_enabled = 1'b1;
        offer({16'(2000) ^ key, 48'd0});
        offer('1);
        clear_state();
    endtask

    task automatic test_limit_lowered();
        logic [63:0] held [$];
        logic [63:0] h;
        clear_state();
        write_limit(10'd40);
        for (int i = 0; i < 35; i++) begin
            h = {$urandom, $urandom};
            held.insert(held.size(), h);
            offer(h);
        end
        write_limit(10'd1);
        offer(held[0]);
        for (int i = 0; i < 6; i++) begin
            h = {$urandom, $urandom};
            offer((h >> (sample_lvl + 1)) << (sample_lvl + 1));
        end
        offer(held[34]);
    endtask

    task automatic test_random_stream();
        int          sent;
        int          phase_len;
        int          r;
        logic [9:0]  lim;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 8)       lim = 10'd0;
            else if (r < 14) lim = 10'd1023;
            else if (r < 20) lim = 10'($urandom_range(0, 1023));
            else             lim = 10'($urandom_range(1, 24));
            write_limit(lim);
            idle_enabled = ($urandom_range(3) != 0);
            if ($urandom_range(99) < 60) begin
                clear_state();
                sent++;
            end
            phase_len = $urandom_range(20, 60);
            for (int i = 0; i < phase_len; i++) begin
                if ($urandom_range(99) < 3) clear_state();
                else offer(shaped_hash());
                sent++;
            end
        end
        idle_enabled = 1'b1;
    endtask

    always @(posedge clk) begin
        if (stall_left > 0) stall_left--;
        else if (idle_enabled && $urandom_range(99) < 20) stall_left = pick_gap();
        rsp_ready <= (stall_left == 0);
    end

    always @(negedge clk) begin : result_monitor
        t_rsp want;
        if (rst_n) begin
            if (rsp_valid && rsp_ready) begin
                if (pending_estimates.size() == 0) begin
                    $error("result with no request outstanding: %p", rsp_data);
                    errors++;
                end else begin
                    want = pending_estimates.pop_front();
                    if (rsp_data.estimate !== want.estimate) begin
                        $error("estimate: expected %0d, got %0d",
                               want.estimate, rsp_data.estimate);
                        errors++;
                    end
                    if (rsp_data.stored_count !== want.stored_count) begin
                        $error("stored_count: expected %0d, got %0d",
                               want.stored_count, rsp_data.stored_count);
                        errors++;
                    end
                    if (rsp_data.sample_level !== want.sample_level) begin
                        $error("sample_level: expected %0d, got %0d",
                               want.sample_level, rsp_data.sample_level);
                        errors++;
                    end
                    if (rsp_data.records_seen !== want.records_seen) begin
                        $error("records_seen: expected %0d, got %0d",
                               want.records_seen, rsp_data.records_seen);
                        errors++;
                    end
                end
            end
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_and_basics();
        test_zero_limit_to_ceiling();
        test_ceiling_fill();
        test_limit_lowered();
        test_random_stream();
        req_valid <= 1'b0;
        while (pending_estimates.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (pending_estimates.size() != 0) begin
            $error("%0d results never arrived", pending_estimates.size());
            errors++;
        end
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
